// ===== rtl/bfe_pkg.sv =====
// Shared constants, opcode encoding and control/status types for the Brainfuck engine.
package bfe_pkg;

    localparam int TAPE_CELLS_D    = 32768;
    localparam int PROGRAM_DEPTH_D = 4096;
    localparam int NEST_DEPTH_D    = 256;
    localparam int INPUT_DEPTH_D   = 256;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_INPUT = 2'd1;
    localparam logic [1:0] CMD_EXEC  = 2'd2;

    localparam logic [2:0] K_ACCEPT  = 3'd0;
    localparam logic [2:0] K_OUTPUT  = 3'd1;
    localparam logic [2:0] K_HALTED  = 3'd2;
    localparam logic [2:0] K_UNCLOSE = 3'd3;
    localparam logic [2:0] K_UNOPEN  = 3'd4;
    localparam logic [2:0] K_FULL    = 3'd5;

    localparam logic [3:0] OP_NOP   = 4'd0;
    localparam logic [3:0] OP_RIGHT = 4'd1;
    localparam logic [3:0] OP_LEFT  = 4'd2;
    localparam logic [3:0] OP_INC   = 4'd3;
    localparam logic [3:0] OP_DEC   = 4'd4;
    localparam logic [3:0] OP_OUT   = 4'd5;
    localparam logic [3:0] OP_IN    = 4'd6;
    localparam logic [3:0] OP_OPEN  = 4'd7;
    localparam logic [3:0] OP_CLOSE = 4'd8;

    localparam logic [7:0] CH_RIGHT = 8'h3E;
    localparam logic [7:0] CH_LEFT  = 8'h3C;
    localparam logic [7:0] CH_INC   = 8'h2B;
    localparam logic [7:0] CH_DEC   = 8'h2D;
    localparam logic [7:0] CH_OUT   = 8'h2E;
    localparam logic [7:0] CH_IN    = 8'h2C;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;

    typedef struct packed {
        logic accept;
        logic begin_load;
        logic clear_step;
        logic ld_a;
        logic ld_pop;
        logic ld_pop2;
        logic ld_end;
        logic ld_fin;
        logic in_op;
        logic ex_op;
        logic load_out;
    } t_ctl;

    typedef struct packed {
        logic loading;
        logic clear_done;
        logic ld_pop;
        logic last;
        logic top_nz;
    } t_sts;

    function automatic logic [3:0] encode_char(input logic [7:0] ch);
        logic [3:0] op;
        case (ch)
            CH_RIGHT: op = OP_RIGHT;
            CH_LEFT:  op = OP_LEFT;
            CH_INC:   op = OP_INC;
            CH_DEC:   op = OP_DEC;
            CH_OUT:   op = OP_OUT;
            CH_IN:    op = OP_IN;
            CH_OPEN:  op = OP_OPEN;
            CH_CLOSE: op = OP_CLOSE;
            default:  op = OP_NOP;
        endcase
        return op;
    endfunction

endpackage

// ===== rtl/bfe_ctrl.sv =====
// Sequencing state machine for the Brainfuck engine: load, input, execute and result handoff.
module bfe_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_command,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  bfe_pkg::t_sts i_sts,
    output bfe_pkg::t_ctl o_ctl
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_BEGIN   = 4'd1;
    localparam logic [3:0] S_CLEAR   = 4'd2;
    localparam logic [3:0] S_LD_A    = 4'd3;
    localparam logic [3:0] S_LD_POP  = 4'd4;
    localparam logic [3:0] S_LD_POP2 = 4'd5;
    localparam logic [3:0] S_LD_END  = 4'd6;
    localparam logic [3:0] S_LD_FIN  = 4'd7;
    localparam logic [3:0] S_INB     = 4'd8;
    localparam logic [3:0] S_EXEC    = 4'd9;
    localparam logic [3:0] S_OUT     = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       in_ready;
    logic       slot_free;

    always_comb begin
        o_ctl       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid;
        in_ready    = 1'b0;
        slot_free   = !r_out_valid || i_out_ready;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
            end
            S_BEGIN: begin
                o_ctl.begin_load = 1'b1;
                n_state          = S_CLEAR;
            end
            S_CLEAR: begin
                o_ctl.clear_step = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = S_LD_A;
                end
            end
            S_LD_A: begin
                o_ctl.ld_a = 1'b1;
                n_state    = i_sts.ld_pop ? S_LD_POP : S_LD_END;
            end
            S_LD_POP: begin
                o_ctl.ld_pop = 1'b1;
                n_state      = S_LD_POP2;
            end
            S_LD_POP2: begin
                o_ctl.ld_pop2 = 1'b1;
                n_state       = S_LD_END;
            end
            S_LD_END: begin
                o_ctl.ld_end = 1'b1;
                n_state      = (i_sts.last && i_sts.top_nz) ? S_LD_FIN : S_OUT;
            end
            S_LD_FIN: begin
                o_ctl.ld_fin = 1'b1;
                n_state      = S_OUT;
            end
            S_INB: begin
                o_ctl.in_op = 1'b1;
                n_state     = S_OUT;
            end
            S_EXEC: begin
                o_ctl.ex_op = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (slot_free) begin
                    o_ctl.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    in_ready       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (in_ready && i_in_valid) begin
            o_ctl.accept = 1'b1;
            case (i_command)
                bfe_pkg::CMD_LOAD:  n_state = i_sts.loading ? S_LD_A : S_BEGIN;
                bfe_pkg::CMD_INPUT: n_state = S_INB;
                bfe_pkg::CMD_EXEC:  n_state = S_EXEC;
                default:            n_state = S_OUT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/bfe_dp.sv =====
// Datapath of the Brainfuck engine: stores, pointers, bracket pairing and instruction execution.
module bfe_dp #(
    parameter int TAPE_CELLS    = bfe_pkg::TAPE_CELLS_D,
    parameter int PROGRAM_DEPTH = bfe_pkg::PROGRAM_DEPTH_D,
    parameter int NEST_DEPTH    = bfe_pkg::NEST_DEPTH_D,
    parameter int INPUT_DEPTH   = bfe_pkg::INPUT_DEPTH_D
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_value,
    input  logic          i_last,
    input  bfe_pkg::t_ctl i_ctl,
    output bfe_pkg::t_sts o_sts,
    output logic [2:0]    o_kind,
    output logic [7:0]    o_data,
    output logic [11:0]   o_position
);

    localparam int AW = $clog2(PROGRAM_DEPTH);
    localparam int TW = $clog2(TAPE_CELLS);
    localparam int SW = $clog2(NEST_DEPTH);
    localparam int IW = $clog2(INPUT_DEPTH);

    localparam logic [AW:0]   PROG_FULL = (AW+1)'(PROGRAM_DEPTH);
    localparam logic [SW:0]   NEST_FULL = (SW+1)'(NEST_DEPTH);
    localparam logic [IW:0]   IN_FULL   = (IW+1)'(INPUT_DEPTH);
    localparam logic [TW-1:0] TAPE_LAST = TW'(TAPE_CELLS - 1);

    logic [3:0]    r_prog_mem  [PROGRAM_DEPTH];
    logic [AW-1:0] r_jump_mem  [PROGRAM_DEPTH];
    logic [AW-1:0] r_stack_mem [NEST_DEPTH];
    logic [7:0]    r_tape_mem  [TAPE_CELLS];
    logic [7:0]    r_inbuf_mem [INPUT_DEPTH];

    logic [3:0]    r_prog_q;
    logic [AW-1:0] r_jump_q;
    logic [AW-1:0] r_stack_q;
    logic [7:0]    r_tape_q;
    logic [7:0]    r_inbuf_q;

    logic [AW:0]   r_len, n_len;
    logic [AW:0]   r_ip, n_ip;
    logic [TW-1:0] r_cp, n_cp;
    logic [SW:0]   r_top, n_top;
    logic [IW:0]   r_in_count, n_in_count;
    logic [IW:0]   r_in_rd, n_in_rd;
    logic          r_ready, n_ready;
    logic          r_loading, n_loading;
    logic          r_failed, n_failed;
    logic [TW-1:0] r_clr, n_clr;
    logic [7:0]    r_value, n_value;
    logic          r_last, n_last;
    logic [AW-1:0] r_close_addr, n_close_addr;
    logic [AW-1:0] r_open_addr, n_open_addr;
    logic [2:0]    r_kind, n_kind;
    logic [7:0]    r_data, n_data;
    logic [11:0]   r_pos, n_pos;
    logic [2:0]    r_out_kind;
    logic [7:0]    r_out_data;
    logic [11:0]   r_out_pos;

    logic          prog_we;
    logic          jump_we;
    logic [AW-1:0] jump_wa;
    logic [AW-1:0] jump_wd;
    logic          stack_we;
    logic          tape_we;
    logic [TW-1:0] tape_wa;
    logic [7:0]    tape_wd;
    logic          inbuf_we;
    logic [SW-1:0] stack_ra;
    logic [SW:0]   top_dec;

    logic [3:0]    op;
    logic          ld_full;
    logic          nest_full;
    logic          ld_ok;
    logic          ex_halt;
    logic          in_avail;
    logic [AW:0]   ip_inc;
    logic [AW:0]   jump_inc;
    logic [AW+11:0] ext_len;
    logic [AW+11:0] ext_stack;

    always_comb begin
        op        = bfe_pkg::encode_char(r_value);
        ld_full   = r_len >= PROG_FULL;
        nest_full = r_top >= NEST_FULL;
        ld_ok     = !ld_full && !(op == bfe_pkg::OP_OPEN && nest_full);
        ex_halt   = !r_ready || (r_ip >= PROG_FULL) || (r_ip >= r_len);
        in_avail  = (r_in_rd < r_in_count) && (r_in_rd < IN_FULL);
        ip_inc    = r_ip + (AW+1)'(1);
        jump_inc  = {1'b0, r_jump_q} + (AW+1)'(1);
        ext_len   = {12'b0, r_len[AW-1:0]};
        ext_stack = {12'b0, r_stack_q};
        top_dec   = r_top - (SW+1)'(1);
        stack_ra  = top_dec[SW-1:0];

        n_len        = r_len;
        n_ip         = r_ip;
        n_cp         = r_cp;
        n_top        = r_top;
        n_in_count   = r_in_count;
        n_in_rd      = r_in_rd;
        n_ready      = r_ready;
        n_loading    = r_loading;
        n_failed     = r_failed;
        n_clr        = r_clr;
        n_value      = r_value;
        n_last       = r_last;
        n_close_addr = r_close_addr;
        n_open_addr  = r_open_addr;
        n_kind       = r_kind;
        n_data       = r_data;
        n_pos        = r_pos;

        prog_we  = 1'b0;
        jump_we  = 1'b0;
        jump_wa  = r_close_addr;
        jump_wd  = r_stack_q;
        stack_we = 1'b0;
        tape_we  = 1'b0;
        tape_wa  = r_cp;
        tape_wd  = 8'd0;
        inbuf_we = 1'b0;

        if (i_ctl.accept) begin
            n_value = i_value;
            n_last  = i_last;
            n_kind  = bfe_pkg::K_ACCEPT;
            n_data  = 8'd0;
            n_pos   = 12'd0;
        end

        if (i_ctl.begin_load) begin
            n_len      = '0;
            n_ip       = '0;
            n_cp       = '0;
            n_top      = '0;
            n_in_count = '0;
            n_in_rd    = '0;
            n_ready    = 1'b0;
            n_failed   = 1'b0;
            n_loading  = 1'b1;
            n_clr      = '0;
        end

        if (i_ctl.clear_step) begin
            tape_we = 1'b1;
            tape_wa = r_clr;
            tape_wd = 8'd0;
            n_clr   = r_clr + TW'(1);
        end

        if (i_ctl.ld_a) begin
            if (!ld_ok) begin
                n_kind   = bfe_pkg::K_FULL;
                n_failed = 1'b1;
            end else begin
                prog_we = 1'b1;
                n_len   = r_len + (AW+1)'(1);
                if (op == bfe_pkg::OP_OPEN) begin
                    stack_we = 1'b1;
                    n_top    = r_top + (SW+1)'(1);
                end else if (op == bfe_pkg::OP_CLOSE) begin
                    if (r_top != '0) begin
                        n_top        = top_dec;
                        n_close_addr = r_len[AW-1:0];
                    end else begin
                        n_kind   = bfe_pkg::K_UNCLOSE;
                        n_pos    = ext_len[11:0];
                        n_failed = 1'b1;
                    end
                end
            end
        end

        if (i_ctl.ld_pop) begin
            jump_we     = 1'b1;
            jump_wa     = r_close_addr;
            jump_wd     = r_stack_q;
            n_open_addr = r_stack_q;
        end

        if (i_ctl.ld_pop2) begin
            jump_we = 1'b1;
            jump_wa = r_open_addr;
            jump_wd = r_close_addr;
        end

        if (i_ctl.ld_end && r_last) begin
            if (r_top != '0) begin
                n_failed = 1'b1;
            end else begin
                n_loading = 1'b0;
                n_ready   = !r_failed;
            end
        end

        if (i_ctl.ld_fin) begin
            n_loading = 1'b0;
            n_ready   = 1'b0;
            if (r_kind == bfe_pkg::K_ACCEPT) begin
                n_kind = bfe_pkg::K_UNOPEN;
                n_pos  = ext_stack[11:0];
            end
        end

        if (i_ctl.in_op) begin
            if (r_in_count >= IN_FULL) begin
                n_kind = bfe_pkg::K_FULL;
            end else begin
                inbuf_we   = 1'b1;
                n_in_count = r_in_count + (IW+1)'(1);
            end
        end

        if (i_ctl.ex_op) begin
            if (ex_halt) begin
                n_kind = bfe_pkg::K_HALTED;
            end else begin
                n_ip = ip_inc;
                case (r_prog_q)
                    bfe_pkg::OP_RIGHT: begin
                        n_cp = (r_cp == TAPE_LAST) ? '0 : r_cp + TW'(1);
                    end
                    bfe_pkg::OP_LEFT: begin
                        n_cp = (r_cp == '0) ? TAPE_LAST : r_cp - TW'(1);
                    end
                    bfe_pkg::OP_INC: begin
                        tape_we = 1'b1;
                        tape_wd = r_tape_q + 8'd1;
                    end
                    bfe_pkg::OP_DEC: begin
                        tape_we = 1'b1;
                        tape_wd = r_tape_q - 8'd1;
                    end
                    bfe_pkg::OP_OUT: begin
                        n_kind = bfe_pkg::K_OUTPUT;
                        n_data = r_tape_q;
                    end
                    bfe_pkg::OP_IN: begin
                        tape_we = 1'b1;
                        if (in_avail) begin
                            tape_wd = r_inbuf_q;
                            n_in_rd = r_in_rd + (IW+1)'(1);
                        end else begin
                            tape_wd = 8'd0;
                        end
                    end
                    bfe_pkg::OP_OPEN: begin
                        if (r_tape_q == 8'd0) begin
                            n_ip = jump_inc;
                        end
                    end
                    bfe_pkg::OP_CLOSE: begin
                        if (r_tape_q != 8'd0) begin
                            n_ip = jump_inc;
                        end
                    end
                    default: begin
                        n_ip = ip_inc;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_ip       <= '0;
            r_cp       <= '0;
            r_top      <= '0;
            r_in_count <= '0;
            r_in_rd    <= '0;
            r_ready    <= 1'b0;
            r_loading  <= 1'b0;
            r_failed   <= 1'b0;
            r_clr      <= '0;
        end else begin
            r_len      <= n_len;
            r_ip       <= n_ip;
            r_cp       <= n_cp;
            r_top      <= n_top;
            r_in_count <= n_in_count;
            r_in_rd    <= n_in_rd;
            r_ready    <= n_ready;
            r_loading  <= n_loading;
            r_failed   <= n_failed;
            r_clr      <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value      <= n_value;
        r_last       <= n_last;
        r_close_addr <= n_close_addr;
        r_open_addr  <= n_open_addr;
        r_kind       <= n_kind;
        r_data       <= n_data;
        r_pos        <= n_pos;
        if (i_ctl.load_out) begin
            r_out_kind <= r_kind;
            r_out_data <= r_data;
            r_out_pos  <= r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (prog_we) begin
            r_prog_mem[r_len[AW-1:0]] <= op;
        end
        r_prog_q <= r_prog_mem[r_ip[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (jump_we) begin
            r_jump_mem[jump_wa] <= jump_wd;
        end
        r_jump_q <= r_jump_mem[r_ip[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (stack_we) begin
            r_stack_mem[r_top[SW-1:0]] <= r_len[AW-1:0];
        end
        r_stack_q <= r_stack_mem[stack_ra];
    end

    always_ff @(posedge i_clk) begin
        if (tape_we) begin
            r_tape_mem[tape_wa] <= tape_wd;
        end
        r_tape_q <= r_tape_mem[r_cp];
    end

    always_ff @(posedge i_clk) begin
        if (inbuf_we) begin
            r_inbuf_mem[r_in_count[IW-1:0]] <= r_value;
        end
        r_inbuf_q <= r_inbuf_mem[r_in_rd[IW-1:0]];
    end

    always_comb begin
        o_sts.loading    = r_loading;
        o_sts.clear_done = (r_clr == TAPE_LAST);
        o_sts.ld_pop     = !ld_full && (op == bfe_pkg::OP_CLOSE) && (r_top != '0);
        o_sts.last       = r_last;
        o_sts.top_nz     = (r_top != '0);
    end

    assign o_kind     = r_out_kind;
    assign o_data     = r_out_data;
    assign o_position = r_out_pos;

endmodule

// ===== rtl/brainfuck_execution_engine.sv =====
// Top level of the Brainfuck engine: ties the controller to the datapath.
//
// Input words carry a command (load program character, append input byte, execute one
// instruction), a value byte and a last mark; each is accepted when i_in_valid and
// o_in_ready are both high. Every input word produces exactly one result word (kind, data,
// position) on the output channel, handed over when o_out_valid and i_out_ready are high.
// An execute word first takes the synchronous reads of program, jump map, tape and input
// buffer, then executes and writes back. An input word appends its byte to the input buffer.
// A load word passes states S_LD_A and S_LD_END, with S_LD_POP and S_LD_POP2 between them
// when a closing bracket is paired (two writes through the single jump-map write port), and
// S_LD_FIN after them when the last character leaves an open bracket. The first load word of
// a program also sweeps the tape to zero, one cell per cycle, before that word completes.
// A finished result waits in the output register; the next word is accepted in the same
// cycle that register is loaded, and if the receiver stalls, the engine holds the following
// result until the register drains. Reset is synchronous and clears all pointers, counts
// and the program-ready flag; no program is ready until a complete load succeeds.
module brainfuck_execution_engine #(
    parameter int TAPE_CELLS    = bfe_pkg::TAPE_CELLS_D,
    parameter int PROGRAM_DEPTH = bfe_pkg::PROGRAM_DEPTH_D,
    parameter int NEST_DEPTH    = bfe_pkg::NEST_DEPTH_D,
    parameter int INPUT_DEPTH   = bfe_pkg::INPUT_DEPTH_D
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_value,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_data,
    output logic [11:0] o_position
);

    bfe_pkg::t_ctl ctl;
    bfe_pkg::t_sts sts;

    bfe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_command),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    bfe_dp #(
        .TAPE_CELLS    (TAPE_CELLS),
        .PROGRAM_DEPTH (PROGRAM_DEPTH),
        .NEST_DEPTH    (NEST_DEPTH),
        .INPUT_DEPTH   (INPUT_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_value    (i_value),
        .i_last     (i_last),
        .i_ctl      (ctl),
        .o_sts      (sts),
        .o_kind     (o_kind),
        .o_data     (o_data),
        .o_position (o_position)
    );

endmodule

// ===== bench/tb_brainfuck_execution_engine.sv =====
// Self-checking testbench for the Brainfuck engine: a directed table, then random programs.
`timescale 1ns / 1ps

module tb_brainfuck_execution_engine;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [11:0] position;
    } t_response;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  val;
        logic        last;
        logic [12:0] reps;
        logic        typed;
        t_response   want;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 27;

    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        '{bfe_pkg::CMD_EXEC, 8'h00, 1'b0, 13'd1, 1'b1, '{bfe_pkg::K_HALTED, 8'h00, 12'd0}},
        '{CMD_UNUSED, 8'hAA, 1'b1, 13'd1, 1'b1, '{bfe_pkg::K_ACCEPT, 8'h00, 12'd0}},
        '{bfe_pkg::CMD_INPUT, 8'h01, 1'b0, 13'd1, 1'b1, '{bfe_pkg::K_ACCEPT, 8'h00, 12'd0}},
        '{bfe_pkg::CMD_LOAD, bfe_pkg::CH_LEFT,  1'b0, 13'd1, 1'b0, '0},
        '{bfe_pkg::CMD_LOAD, bfe_pkg::CH_INC,   1'b0, 13'd1, 1'b0, '0},
        '{bfe_pkg::CMD_LOAD, bfe_pkg::CH_OUT,   1'b0, 13'd1, 1'b0, '0},
        '{bfe_pkg::CMD_LOAD, bfe_pkg::CH_IN,    1'b0, 13'd1, 1'b0, '0},
        '{bfe_pkg::CMD_LOAD, bfe_pkg::CH_OUT,   1'b0, 13'd1, 1'b0, '0},
        '{bfe_pkg::CMD_LOAD, bfe_pkg::CH_IN,    1'b0, 13'd1, 1'b0, '0},
        '{bfe_pkg::CMD_LOAD, bfe_pkg::CH_INC,   1'b0, 13'd1, 1'b0, '0},
        '{bfe_pkg::CMD_LOAD, bfe_pkg::CH_OPEN,  1'b0, 13'd1, 1'b0, '0},
        '{bfe_pkg::CMD_LOAD, bfe_pkg::CH_DEC,   1'b0, 13'd1, 1'b0, '0},
        '{bfe_pkg::CMD_LOAD, bfe_pkg::CH_CLOSE, 1'b0, 13'd1, 1'b0, '0},
        '{bfe_pkg::CMD_LOAD, bfe_pkg::CH_RIGHT, 1'b0, 13'd1, 1'b0, '0},
        '{bfe_pkg::CMD_LOAD, 8'hFF, 1'b1, 13'd1, 1'b0, '0},
        '{bfe_pkg::CMD_INPUT, 8'h80, 1'b0, 13'd1, 1'b0, '0},
        '{bfe_pkg::CMD_EXEC, 8'h00, 1'b0, 13'd20, 1'b0, '0},
        '{bfe_pkg::CMD_INPUT, 8'h00, 1'b0, 13'd256, 1'b0, '0},
        '{bfe_pkg::CMD_INPUT, 8'hFF, 1'b0, 13'd1, 1'b1, '{bfe_pkg::K_FULL, 8'h00, 12'd0}},
        '{bfe_pkg::CMD_LOAD, 8'h00, 1'b0, 13'd3, 1'b0, '0},
        '{bfe_pkg::CMD_LOAD, bfe_pkg::CH_CLOSE, 1'b0, 13'd1, 1'b1,
          '{bfe_pkg::K_UNCLOSE, 8'h00, 12'd3}},
        '{bfe_pkg::CMD_LOAD, bfe_pkg::CH_OPEN, 1'b1, 13'd1, 1'b1,
          '{bfe_pkg::K_UNOPEN, 8'h00, 12'd4}},
        '{bfe_pkg::CMD_EXEC, 8'h00, 1'b0, 13'd1, 1'b1, '{bfe_pkg::K_HALTED, 8'h00, 12'd0}},
        '{bfe_pkg::CMD_LOAD, bfe_pkg::CH_OPEN, 1'b0, 13'd256, 1'b0, '0},
        '{bfe_pkg::CMD_LOAD, bfe_pkg::CH_OPEN, 1'b0, 13'd1, 1'b1,
          '{bfe_pkg::K_FULL, 8'h00, 12'd0}},
        '{bfe_pkg::CMD_LOAD, bfe_pkg::CH_INC, 1'b1, 13'd1, 1'b1,
          '{bfe_pkg::K_UNOPEN, 8'h00, 12'd255}},
        '{bfe_pkg::CMD_EXEC, 8'hFF, 1'b1, 13'd1, 1'b1, '{bfe_pkg::K_HALTED, 8'h00, 12'd0}}
    };

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [1:0]  i_command   = bfe_pkg::CMD_EXEC;
    logic [7:0]  i_value     = 8'h00;
    logic        i_last      = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [2:0]  o_kind;
    logic [7:0]  o_data;
    logic [11:0] o_position;

    bit [3:0]  prog_mem   [bfe_pkg::PROGRAM_DEPTH_D];
    bit [11:0] jump_mem   [bfe_pkg::PROGRAM_DEPTH_D];
    bit [11:0] nest_stack [bfe_pkg::NEST_DEPTH_D];
    bit [7:0]  tape_mem   [bfe_pkg::TAPE_CELLS_D];
    bit [7:0]  in_fifo    [bfe_pkg::INPUT_DEPTH_D];
    int        nest_top;
    int        in_count;
    int        in_rd;
    int        prog_len;
    int        pc;
    int        tape_ptr;
    bit        prog_ok;
    bit        load_busy;
    bit        load_bad;

    t_response pending_responses [$];
    t_response head_response;
    int        error_count    = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;

    brainfuck_execution_engine uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_value     (i_value),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_kind      (o_kind),
        .o_data      (o_data),
        .o_position  (o_position)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(40_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic t_response engine_response(input logic [1:0] cmd, input logic [7:0] val,
                                                  input logic last);
        t_response r;
        logic [3:0] op;
        int addr;
        int ip;
        r = '0;
        case (cmd)
            bfe_pkg::CMD_LOAD: begin
                if (!load_busy) begin
                    for (int i = 0; i < bfe_pkg::TAPE_CELLS_D; i++) tape_mem[i] = 8'h00;
                    nest_top  = 0;
                    in_count  = 0;
                    in_rd     = 0;
                    prog_len  = 0;
                    pc        = 0;
                    tape_ptr  = 0;
                    prog_ok   = 1'b0;
                    load_bad  = 1'b0;
                    load_busy = 1'b1;
                end
                case (val)
                    bfe_pkg::CH_RIGHT: op = bfe_pkg::OP_RIGHT;
                    bfe_pkg::CH_LEFT:  op = bfe_pkg::OP_LEFT;
                    bfe_pkg::CH_INC:   op = bfe_pkg::OP_INC;
                    bfe_pkg::CH_DEC:   op = bfe_pkg::OP_DEC;
                    bfe_pkg::CH_OUT:   op = bfe_pkg::OP_OUT;
                    bfe_pkg::CH_IN:    op = bfe_pkg::OP_IN;
                    bfe_pkg::CH_OPEN:  op = bfe_pkg::OP_OPEN;
                    bfe_pkg::CH_CLOSE: op = bfe_pkg::OP_CLOSE;
                    default:           op = bfe_pkg::OP_NOP;
                endcase
                if (prog_len >= bfe_pkg::PROGRAM_DEPTH_D) begin
                    r.kind   = bfe_pkg::K_FULL;
                    load_bad = 1'b1;
                end else if (op == bfe_pkg::OP_OPEN && nest_top >= bfe_pkg::NEST_DEPTH_D) begin
                    r.kind   = bfe_pkg::K_FULL;
                    load_bad = 1'b1;
                end else begin
                    addr           = prog_len;
                    prog_mem[addr] = op;
                    jump_mem[addr] = '0;
                    prog_len       = addr + 1;
                    if (op == bfe_pkg::OP_OPEN) begin
                        nest_stack[nest_top] = 12'(addr);
                        nest_top++;
                    end else if (op == bfe_pkg::OP_CLOSE) begin
                        if (nest_top > 0) begin
                            nest_top--;
                            jump_mem[addr]                 = nest_stack[nest_top];
                            jump_mem[nest_stack[nest_top]] = 12'(addr);
                        end else begin
                            r.kind     = bfe_pkg::K_UNCLOSE;
                            r.position = 12'(addr);
                            load_bad   = 1'b1;
                        end
                    end
                end
                if (last) begin
                    if (nest_top > 0) begin
                        load_bad = 1'b1;
                        if (r.kind == bfe_pkg::K_ACCEPT) begin
                            r.kind     = bfe_pkg::K_UNOPEN;
                            r.position = nest_stack[nest_top - 1];
                        end
                    end
                    load_busy = 1'b0;
                    prog_ok   = !load_bad;
                end
            end
            bfe_pkg::CMD_INPUT: begin
                if (in_count >= bfe_pkg::INPUT_DEPTH_D) begin
                    r.kind = bfe_pkg::K_FULL;
                end else begin
                    in_fifo[in_count] = val;
                    in_count++;
                end
            end
            bfe_pkg::CMD_EXEC: begin
                if (!prog_ok || pc >= prog_len) begin
                    r.kind = bfe_pkg::K_HALTED;
                end else begin
                    ip = pc;
                    case (prog_mem[ip])
                        bfe_pkg::OP_RIGHT: begin
                            tape_ptr = (tape_ptr + 1 >= bfe_pkg::TAPE_CELLS_D) ? 0 : tape_ptr + 1;
                        end
                        bfe_pkg::OP_LEFT: begin
                            tape_ptr = (tape_ptr == 0) ? bfe_pkg::TAPE_CELLS_D - 1 : tape_ptr - 1;
                        end
                        bfe_pkg::OP_INC: tape_mem[tape_ptr] = tape_mem[tape_ptr] + 8'd1;
                        bfe_pkg::OP_DEC: tape_mem[tape_ptr] = tape_mem[tape_ptr] - 8'd1;
                        bfe_pkg::OP_OUT: begin
                            r.kind = bfe_pkg::K_OUTPUT;
                            r.data = tape_mem[tape_ptr];
                        end
                        bfe_pkg::OP_IN: begin
                            if (in_rd < in_count && in_rd < bfe_pkg::INPUT_DEPTH_D) begin
                                tape_mem[tape_ptr] = in_fifo[in_rd];
                                in_rd++;
                            end else begin
                                tape_mem[tape_ptr] = 8'h00;
                            end
                        end
                        bfe_pkg::OP_OPEN: begin
                            if (tape_mem[tape_ptr] == 8'h00) ip = int'(jump_mem[ip]);
                        end
                        bfe_pkg::OP_CLOSE: begin
                            if (tape_mem[tape_ptr] != 8'h00) ip = int'(jump_mem[ip]);
                        end
                        default: ;
                    endcase
                    pc = ip + 1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic send_word(input logic [1:0] cmd, input logic [7:0] val, input logic last,
                             input logic typed = 1'b0, input t_response want = '0);
        t_response r;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_value    <= val;
        i_last     <= last;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        r = engine_response(cmd, val, last);
        pending_responses.push_back(typed ? want : r);
    endtask

    function automatic logic [7:0] random_plain_char();
        case ($urandom_range(6))
            0:       return bfe_pkg::CH_RIGHT;
            1:       return bfe_pkg::CH_LEFT;
            2:       return bfe_pkg::CH_INC;
            3:       return bfe_pkg::CH_DEC;
            4:       return bfe_pkg::CH_OUT;
            5:       return bfe_pkg::CH_IN;
            default: return bfe_pkg::CH_INC;
        endcase
    endfunction

    task automatic send_program(input bit well_formed);
        logic [7:0] chars [$];
        int len;
        int depth;
        int pick;
        logic [7:0] ch;
        len   = $urandom_range(8, 60);
        depth = 0;
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(99);
            if (well_formed) begin
                if (pick < 8 && depth < 6) begin
                    ch = bfe_pkg::CH_OPEN;
                    depth++;
                end else if (pick < 16 && depth > 0) begin
                    ch = bfe_pkg::CH_CLOSE;
                    depth--;
                end else if (pick < 22) begin
                    ch = 8'($urandom_range(255));
                    if (ch == bfe_pkg::CH_OPEN || ch == bfe_pkg::CH_CLOSE) ch = 8'h00;
                end else begin
                    ch = random_plain_char();
                end
            end else begin
                if (pick < 15) ch = bfe_pkg::CH_OPEN;
                else if (pick < 30) ch = bfe_pkg::CH_CLOSE;
                else if (pick < 40) ch = 8'($urandom_range(255));
                else ch = random_plain_char();
            end
            chars.push_back(ch);
        end
        while (depth > 0) begin
            chars.push_back(bfe_pkg::CH_CLOSE);
            depth--;
        end
        for (int i = 0; i < chars.size(); i++) begin
            if ($urandom_range(99) < 5) begin
                send_word(bfe_pkg::CMD_INPUT, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            send_word(bfe_pkg::CMD_LOAD, chars[i], i == chars.size() - 1);
        end
    endtask

    always @(posedge i_clk) begin
        if (o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_responses.size() == 0) begin
                report_error($sformatf("unexpected result word, kind %0d", o_kind));
            end else begin
                head_response = pending_responses.pop_front();
                if (o_kind !== head_response.kind) begin
                    report_error($sformatf("kind %0d, expected %0d", o_kind,
                                           head_response.kind));
                end
                if (o_data !== head_response.data) begin
                    report_error($sformatf("data 0x%02h, expected 0x%02h", o_data,
                                           head_response.data));
                end
                if (o_position !== head_response.position) begin
                    report_error($sformatf("position %0d, expected %0d", o_position,
                                           head_response.position));
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        int pick;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            repeat (DIRECTED[r].reps) begin
                send_word(DIRECTED[r].cmd, DIRECTED[r].val, DIRECTED[r].last,
                          DIRECTED[r].typed, DIRECTED[r].want);
            end
        end

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                1: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                2: begin send_idle_pct = 33; recv_stall_pct = 33; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            send_program($urandom_range(99) >= 20);
            repeat ($urandom_range(12)) begin
                send_word(bfe_pkg::CMD_INPUT, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            repeat ($urandom_range(80, 160)) begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    send_word(bfe_pkg::CMD_INPUT, 8'($urandom_range(255)),
                              1'($urandom_range(1)));
                end else if (pick < 11) begin
                    send_word(CMD_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)));
                end else begin
                    send_word(bfe_pkg::CMD_EXEC, 8'($urandom_range(255)),
                              1'($urandom_range(1)));
                end
            end
        end

        i_in_valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
